// File: sv/pbrle_pkg.sv
// Package for the PackBits-style run-length encoder.
// Holds the request payload types and the fixed constants; depends on nothing.
package pbrle_pkg;

  // One uncompressed byte and its end-of-stream mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } raw_t;

  // One compressed byte with its framing marks.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       burst_last;
    logic       stream_done;
  } enc_t;

  localparam logic [6:0] MIN_RUN         = 7'd3;
  localparam logic [6:0] RUN_LIMIT_RESET = 7'd127;

  // Register index of run_limit on the configuration port.
  localparam logic       REG_RUN_LIMIT   = 1'b0;

endpackage

// File: sv/packbits_style_rle_encoder.sv
// Flow: an input request is taken in S_IDLE and decided in the next cycle, in S_DECIDE; each repeat
// record byte and each literal header is sent from its own state, each literal byte by S_FL_RD (a
// read of the literal memory) and then S_FL_DAT (the transfer); sending waits while the result stage is stalled.
// No new input byte is taken before the last one is done; the input stalls from acceptance until the
// last output byte has been registered.
// Synchronous reset clears the run, literal count and output stage; run_limit is 127.
module packbits_style_rle_encoder #(
  parameter int MAX_LITERAL = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              raw_valid,
  output logic              raw_stall,
  input  pbrle_pkg::raw_t   raw_item,
  output logic              enc_valid,
  input  logic              enc_stall,
  output pbrle_pkg::enc_t   enc_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CW = $clog2(MAX_LITERAL + 1);
  localparam int AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_LITERAL);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_REP_A_CNT,
    S_REP_A_VAL,
    S_FL_HDR,
    S_FL_RD,
    S_FL_DAT,
    S_REP_B_CNT,
    S_REP_B_VAL
  } state_t;

  state_t        state;
  logic [7:0]    run_value;
  logic [6:0]    run_length;
  logic [CW-1:0] lit_count;
  logic [6:0]    run_limit;
  logic [7:0]    cur_byte;
  logic          cur_end;
  logic [6:0]    rep_a_cnt;
  logic [7:0]    rep_a_val;
  logic [6:0]    rep_b_cnt;
  logic          pend_b;
  logic [CW-1:0] flush_k;
  logic [AW-1:0] fl_idx;
  logic [7:0]    rd_data;
  logic [7:0]    lit_mem [MAX_LITERAL];

  // Decision for the current request.
  logic          d_rep_a;
  logic          d_rep_b;
  logic [6:0]    d_rep_b_cnt;
  logic [6:0]    run_length_next;
  logic [7:0]    run_value_next;
  logic [CW-1:0] lit_count_next;
  logic [CW-1:0] d_flush_k;
  logic          d_wr;
  logic [6:0]    lim;
  logic          push_ok;
  logic          out_push;
  logic          cfg_wr;
  logic          fl_last;

  assign raw_stall = (state != S_IDLE);
  assign push_ok   = !enc_valid || !enc_stall;
  assign out_push  = push_ok && (state inside {S_REP_A_CNT, S_REP_A_VAL, S_FL_HDR, S_FL_DAT,
                                               S_REP_B_CNT, S_REP_B_VAL});
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == pbrle_pkg::REG_RUN_LIMIT);
  assign prdata    = (paddr[2] == pbrle_pkg::REG_RUN_LIMIT) ? {25'd0, run_limit} : 32'd0;
  assign lim       = (run_limit < pbrle_pkg::MIN_RUN) ? pbrle_pkg::MIN_RUN : run_limit;
  assign fl_last   = ((CW'(fl_idx) + CW'(1)) == flush_k);

  always_comb begin
    logic          app;
    logic [CW-1:0] cnt_a;
    logic [7:0]    cnt8;
    app             = 1'b0;
    cnt_a           = lit_count;
    cnt8            = 8'(lit_count);
    d_rep_a         = 1'b0;
    d_rep_b         = 1'b0;
    d_rep_b_cnt     = run_length;
    d_wr            = 1'b0;
    d_flush_k       = '0;
    run_length_next = run_length;
    run_value_next  = run_value;
    lit_count_next  = lit_count;

    if (run_length != 7'd0 && cur_byte == run_value) begin
      if (run_length >= pbrle_pkg::MIN_RUN) begin
        run_length_next = run_length + 7'd1;
      end else if (run_length == 7'd2) begin
        // The two earlier copies leave the literal store; older literals go out first.
        d_flush_k       = (cnt8 >= 8'd2) ? CW'(cnt8 - 8'd2) : '0;
        lit_count_next  = '0;
        run_length_next = pbrle_pkg::MIN_RUN;
      end else begin
        run_length_next = 7'd2;
        app             = 1'b1;
      end
    end else begin
      d_rep_a         = (run_length >= pbrle_pkg::MIN_RUN);
      run_value_next  = cur_byte;
      run_length_next = 7'd1;
      app             = 1'b1;
    end

    if (app) begin
      if (lit_count < MaxCnt) begin
        d_wr  = 1'b1;
        cnt_a = lit_count + CW'(1);
      end
      if (cnt_a >= MaxCnt) begin
        // A full store is flushed at once and closes any short run with it.
        d_flush_k       = MaxCnt;
        lit_count_next  = '0;
        run_length_next = 7'd0;
      end else begin
        lit_count_next = cnt_a;
      end
    end

    if (run_length_next >= pbrle_pkg::MIN_RUN && run_length_next >= lim) begin
      d_rep_b         = 1'b1;
      d_rep_b_cnt     = run_length_next;
      run_length_next = 7'd0;
    end

    if (cur_end) begin
      if (run_length_next >= pbrle_pkg::MIN_RUN) begin
        d_rep_b     = 1'b1;
        d_rep_b_cnt = run_length_next;
      end
      if (lit_count_next != '0) begin
        d_flush_k = lit_count_next;
      end
      lit_count_next  = '0;
      run_length_next = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE && d_wr) begin
      lit_mem[AW'(lit_count)] <= cur_byte;
    end
    rd_data <= lit_mem[fl_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      enc_valid  <= 1'b0;
      run_value  <= 8'd0;
      run_length <= 7'd0;
      lit_count  <= '0;
      run_limit  <= pbrle_pkg::RUN_LIMIT_RESET;
      pend_b     <= 1'b0;
      flush_k    <= '0;
      fl_idx     <= '0;
    end else begin
      enc_valid <= out_push || (enc_valid && enc_stall);
      if (cfg_wr) begin
        run_limit <= pwdata[6:0];
      end

      case (state)
        S_IDLE: begin
          if (raw_valid) begin
            cur_byte <= raw_item.in_byte;
            cur_end  <= raw_item.stream_end;
            state    <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          rep_a_cnt  <= run_length;
          rep_a_val  <= run_value;
          rep_b_cnt  <= d_rep_b_cnt;
          pend_b     <= d_rep_b;
          flush_k    <= d_flush_k;
          fl_idx     <= '0;
          run_value  <= run_value_next;
          run_length <= run_length_next;
          lit_count  <= lit_count_next;
          if (d_rep_a) begin
            state <= S_REP_A_CNT;
          end else if (d_flush_k != '0) begin
            state <= S_FL_HDR;
          end else if (d_rep_b) begin
            state <= S_REP_B_CNT;
          end else begin
            state <= S_IDLE;
          end
        end

        S_REP_A_CNT: begin
          if (push_ok) begin
            enc_item  <= '{out_byte: {1'b0, rep_a_cnt}, burst_last: 1'b0, stream_done: 1'b0};
            state     <= S_REP_A_VAL;
          end
        end

        S_REP_A_VAL: begin
          if (push_ok) begin
            enc_item  <= '{out_byte: rep_a_val,
                           burst_last: (flush_k == '0) && !pend_b,
                           stream_done: (flush_k == '0) && !pend_b && cur_end};
            if (flush_k != '0) begin
              state <= S_FL_HDR;
            end else if (pend_b) begin
              state <= S_REP_B_CNT;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_FL_HDR: begin
          if (push_ok) begin
            enc_item  <= '{out_byte: 8'd0 - 8'(flush_k), burst_last: 1'b0, stream_done: 1'b0};
            state     <= S_FL_RD;
          end
        end

        // The memory read of fl_idx lands in rd_data during this cycle.
        S_FL_RD: begin
          state <= S_FL_DAT;
        end

        S_FL_DAT: begin
          if (push_ok) begin
            enc_item  <= '{out_byte: rd_data,
                           burst_last: fl_last && !pend_b,
                           stream_done: fl_last && !pend_b && cur_end};
            if (!fl_last) begin
              fl_idx <= fl_idx + AW'(1);
              state  <= S_FL_RD;
            end else if (pend_b) begin
              state <= S_REP_B_CNT;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_REP_B_CNT: begin
          if (push_ok) begin
            enc_item  <= '{out_byte: {1'b0, rep_b_cnt}, burst_last: 1'b0, stream_done: 1'b0};
            state     <= S_REP_B_VAL;
          end
        end

        S_REP_B_VAL: begin
          if (push_ok) begin
            enc_item  <= '{out_byte: run_value, burst_last: 1'b1, stream_done: cur_end};
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
